### src/quat_to_euler_angles_unit_defines.svh
// ----------------------------------------------------------------------------
// quat_to_euler_angles_unit_defines.svh
// Assertion macros shared by the checker of the quaternion to Euler unit.
// ----------------------------------------------------------------------------
`ifndef QUAT_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUAT_TO_EULER_ANGLES_UNIT_DEFINES_SVH

// clocked assertion with active-low reset disable
`define Q2E_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a signed field stays within +/- lim while its beat is valid
`define Q2E_ASSERT_RANGE(lbl, clk, rstn, vld, sig, lim, msg) \
  `Q2E_ASSERT(lbl, clk, rstn, (vld) |-> (((sig) <= (lim)) && ((sig) >= -(lim))), msg)

`endif

### src/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Widths, constants, stage payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int IN_W      = 16;
  localparam int PROD_W    = 32;  // 16x16 signed product
  localparam int PW        = 36;  // numerators and denominators, Q8.28
  localparam int SW        = 30;  // clamped arcsine argument
  localparam int SABS_W    = 28;
  localparam int RW        = 57;  // sqrt remainder, holds 2^56
  localparam int QW        = 58;  // sqrt partial root
  localparam int ROOT_W    = 29;  // final root, at most 2^28
  localparam int CW        = 38;  // CORDIC coordinates
  localparam int AW        = 34;  // Q30 angle accumulator
  localparam int OUT_W     = 16;
  localparam int PITCH_W   = 15;
  localparam int SHIFT     = 17;

  localparam int FRONT_STAGES      = 3;
  localparam int SQRT_STEPS        = 29;
  localparam int TABLE_LEN         = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [PW-1:0] ASIN_LIMIT  = 36'sd268432772;
  localparam logic [RW-1:0]        ONE_Q56     = {1'b1, 56'b0};
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW:0]   ROUND_Q30   = 35'sd65536;
  localparam int PI_Q13_MAX      = 25736;
  localparam int HALF_PI_Q13_MAX = 12868;

  typedef struct packed {
    logic signed [PW-1:0] roll_n;
    logic signed [PW-1:0] roll_d;
    logic signed [PW-1:0] yaw_n;
    logic signed [PW-1:0] yaw_d;
    logic signed [SW-1:0] s;
    logic [RW-1:0]        rem;
    logic [QW-1:0]        root;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t roll;
    vec_t pitch;
    vec_t yaw;
  } cor_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [AW-1:0] atan_q30(input int unsigned idx);
    logic signed [AW-1:0] v;
    unique case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/q2e_if.sv
// ----------------------------------------------------------------------------
// q2e_quat_if / q2e_angle_if
// Valid/ready channels for quaternion beats and angle beats.
// ----------------------------------------------------------------------------
interface q2e_quat_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   quat_w;
  logic signed [15:0]   quat_x;
  logic signed [15:0]   quat_y;
  logic signed [15:0]   quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_angle_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   roll_angle;
  logic signed [14:0]   pitch_angle;
  logic signed [15:0]   yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### src/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Three stages: quaternion products, sums with arcsine clamp, 1 - s^2.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                             clk_i,
  input  logic [q2e_pkg::FRONT_STAGES-1:0] en_i,
  input  logic signed [q2e_pkg::IN_W-1:0]  w_i,
  input  logic signed [q2e_pkg::IN_W-1:0]  x_i,
  input  logic signed [q2e_pkg::IN_W-1:0]  y_i,
  input  logic signed [q2e_pkg::IN_W-1:0]  z_i,
  output q2e_pkg::sq_t                     data_o
);

  localparam int PR = q2e_pkg::PROD_W;
  localparam int PW = q2e_pkg::PW;
  localparam int SW = q2e_pkg::SW;

  logic signed [PR-1:0] xy_q, wz_q, yz_q, wx_q, xz_q, wy_q, ww_q, xx_q, yy_q, zz_q;
  logic signed [PW-1:0] roll_n_q, roll_d_q, yaw_n_q, yaw_d_q;
  logic signed [PW-1:0] roll_n_d, roll_d_d, yaw_n_d, yaw_d_d, s_raw;
  logic signed [SW-1:0] s_q, s_d;
  logic [q2e_pkg::SABS_W-1:0]   s_abs;
  logic [2*q2e_pkg::SABS_W-1:0] s_sq;
  q2e_pkg::sq_t         data_d, data_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xy_q <= x_i * y_i;
      wz_q <= w_i * z_i;
      yz_q <= y_i * z_i;
      wx_q <= w_i * x_i;
      xz_q <= x_i * z_i;
      wy_q <= w_i * y_i;
      ww_q <= w_i * w_i;
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      zz_q <= z_i * z_i;
    end
  end

  always_comb begin
    yaw_n_d  = (PW'(xy_q) + PW'(wz_q)) <<< 1;
    yaw_d_d  = PW'(ww_q) + PW'(xx_q) - PW'(yy_q) - PW'(zz_q);
    roll_n_d = (PW'(yz_q) + PW'(wx_q)) <<< 1;
    roll_d_d = PW'(ww_q) - PW'(xx_q) - PW'(yy_q) + PW'(zz_q);
    s_raw    = (PW'(wy_q) - PW'(xz_q)) <<< 1;
    if (s_raw > q2e_pkg::ASIN_LIMIT) begin
      s_d = SW'(q2e_pkg::ASIN_LIMIT);
    end else if (s_raw < -q2e_pkg::ASIN_LIMIT) begin
      s_d = SW'(-q2e_pkg::ASIN_LIMIT);
    end else begin
      s_d = SW'(s_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      yaw_n_q  <= yaw_n_d;
      yaw_d_q  <= yaw_d_d;
      roll_n_q <= roll_n_d;
      roll_d_q <= roll_d_d;
      s_q      <= s_d;
    end
  end

  always_comb begin
    s_abs         = s_q[SW-1] ? q2e_pkg::SABS_W'(-s_q) : q2e_pkg::SABS_W'(s_q);
    s_sq          = s_abs * s_abs;
    data_d.roll_n = roll_n_q;
    data_d.roll_d = roll_d_q;
    data_d.yaw_n  = yaw_n_q;
    data_d.yaw_d  = yaw_d_q;
    data_d.s      = s_q;
    data_d.rem    = q2e_pkg::ONE_Q56 - q2e_pkg::RW'(s_sq);
    data_d.root   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### src/q2e_sqrt_step.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_step
// One registered step of the bit-pair integer square root.
// ----------------------------------------------------------------------------
module q2e_sqrt_step #(
  parameter int STEP = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  q2e_pkg::sq_t data_i,
  output q2e_pkg::sq_t data_o
);

  localparam int QW = q2e_pkg::QW;
  localparam int BIT_POS = 2 * (q2e_pkg::SQRT_STEPS - 1 - STEP);
  localparam logic [QW-1:0] BIT = QW'(1) << BIT_POS;

  logic [QW-1:0] trial;
  q2e_pkg::sq_t  data_d, data_q;

  always_comb begin
    data_d = data_i;
    trial  = data_i.root + BIT;
    if ({1'b0, data_i.rem} >= trial) begin
      data_d.rem  = data_i.rem - q2e_pkg::RW'(trial);
      data_d.root = (data_i.root >> 1) + BIT;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### src/q2e_prerot.sv
// ----------------------------------------------------------------------------
// q2e_prerot
// Loads the three CORDIC vectors, folding the left half-plane by +/- pi/2.
// ----------------------------------------------------------------------------
module q2e_prerot (
  input  logic          clk_i,
  input  logic          en_i,
  input  q2e_pkg::sq_t  data_i,
  output q2e_pkg::cor_t data_o
);

  localparam int CW = q2e_pkg::CW;

  function automatic q2e_pkg::vec_t load(input logic signed [CW-1:0] num,
                                         input logic signed [CW-1:0] den);
    q2e_pkg::vec_t v;
    v.zero = (num == '0) && (den == '0);
    v.x    = den;
    v.y    = num;
    v.ang  = '0;
    if (den < 0) begin
      if (num >= 0) begin
        v.x   = num;
        v.y   = -den;
        v.ang = q2e_pkg::HALF_PI_Q30;
      end else begin
        v.x   = -num;
        v.y   = den;
        v.ang = -q2e_pkg::HALF_PI_Q30;
      end
    end
    return v;
  endfunction

  logic signed [CW-1:0] cos_val;
  q2e_pkg::cor_t        data_d, data_q;

  always_comb begin
    cos_val      = CW'($signed({1'b0, data_i.root[q2e_pkg::ROOT_W-1:0]}));
    data_d.roll  = load(CW'(data_i.roll_n), CW'(data_i.roll_d));
    data_d.pitch = load(CW'(data_i.s), cos_val);
    data_d.yaw   = load(CW'(data_i.yaw_n), CW'(data_i.yaw_d));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### src/q2e_cordic_step.sv
// ----------------------------------------------------------------------------
// q2e_cordic_step
// One registered vectoring iteration, applied to all three vectors.
// ----------------------------------------------------------------------------
module q2e_cordic_step #(
  parameter int STEP = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  q2e_pkg::cor_t data_i,
  output q2e_pkg::cor_t data_o
);

  localparam logic signed [q2e_pkg::AW-1:0] ATAN = q2e_pkg::atan_q30(STEP);

  function automatic q2e_pkg::vec_t rotate(input q2e_pkg::vec_t v);
    q2e_pkg::vec_t r;
    logic signed [q2e_pkg::CW-1:0] xs, ys;
    xs = v.x >>> STEP;
    ys = v.y >>> STEP;
    r  = v;
    if (!v.y[q2e_pkg::CW-1]) begin
      r.x   = v.x + ys;
      r.y   = v.y - xs;
      r.ang = v.ang + ATAN;
    end else begin
      r.x   = v.x - ys;
      r.y   = v.y + xs;
      r.ang = v.ang - ATAN;
    end
    return r;
  endfunction

  q2e_pkg::cor_t data_d, data_q;

  always_comb begin
    data_d.roll  = rotate(data_i.roll);
    data_d.pitch = rotate(data_i.pitch);
    data_d.yaw   = rotate(data_i.yaw);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### src/q2e_out.sv
// ----------------------------------------------------------------------------
// q2e_out
// Q30 angles to rounded, saturated Q3.13 output register.
// ----------------------------------------------------------------------------
module q2e_out (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  q2e_pkg::cor_t                       data_i,
  output logic signed [q2e_pkg::OUT_W-1:0]    roll_o,
  output logic signed [q2e_pkg::PITCH_W-1:0]  pitch_o,
  output logic signed [q2e_pkg::OUT_W-1:0]    yaw_o
);

  localparam int AW = q2e_pkg::AW;
  localparam int RW = AW + 1 - q2e_pkg::SHIFT;

  function automatic logic signed [q2e_pkg::OUT_W-1:0] to_q13(input q2e_pkg::vec_t v,
                                                              input int lim);
    logic signed [AW:0]   sum;
    logic signed [RW-1:0] r, hi;
    logic signed [q2e_pkg::OUT_W-1:0] res;
    sum = (AW+1)'(v.ang) + q2e_pkg::ROUND_Q30;
    r   = sum[AW:q2e_pkg::SHIFT];
    hi  = RW'(lim);
    if (v.zero) begin
      res = '0;
    end else if (r > hi) begin
      res = q2e_pkg::OUT_W'(hi);
    end else if (r < -hi) begin
      res = q2e_pkg::OUT_W'(-hi);
    end else begin
      res = q2e_pkg::OUT_W'(r);
    end
    return res;
  endfunction

  logic signed [q2e_pkg::OUT_W-1:0] pitch_full;
  logic signed [q2e_pkg::OUT_W-1:0] roll_q, yaw_q;
  logic signed [q2e_pkg::PITCH_W-1:0] pitch_q;

  assign pitch_full = to_q13(data_i.pitch, q2e_pkg::HALF_PI_Q13_MAX);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      roll_q  <= to_q13(data_i.roll, q2e_pkg::PI_Q13_MAX);
      pitch_q <= pitch_full[q2e_pkg::PITCH_W-1:0];
      yaw_q   <= to_q13(data_i.yaw, q2e_pkg::PI_Q13_MAX);
    end
  end

  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;

endmodule

### src/quat_to_euler_angles_unit.sv
// ----------------------------------------------------------------------------
// quat_to_euler_angles_unit
// Unit quaternion (Q2.14) to roll, pitch, yaw in radians (Q3.13).
// ----------------------------------------------------------------------------
// Usage:
//   quat_i carries one quaternion per beat (w, x, y, z); angle_o returns one
//   beat with roll, pitch and yaw for every input beat, in order.
//   Pitch is the arcsine of the clamped -2(xz - wy), formed as an atan2 over
//   an integer square root; every atan2 is a vectoring CORDIC.
//   Pipeline: 3 product/sum stages, 29 square root steps, one quadrant
//   fold, one stage per CORDIC iteration and one output register; the
//   default is 16 iterations.
//   Throughput: one beat per cycle while angle_o is not stalled; the pipeline length is set by the
//   one-bit-pair-per-stage square root and the unrolled CORDIC.
//   Each stage has a valid bit; a stage loads whenever it is empty or the
//   stage after it moves, so bubbles close up while angle_o is stalled and
//   quat_i keeps accepting until every stage holds a beat.
//   Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module quat_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  q2e_quat_if.sink      quat_i,
  q2e_angle_if.source   angle_o
);

  localparam int FS = q2e_pkg::FRONT_STAGES;
  localparam int SQ = q2e_pkg::SQRT_STEPS;
  localparam int PR_IDX = FS + SQ;
  localparam int CO_IDX = PR_IDX + 1;
  localparam int OUT_IDX = CO_IDX + CORDIC_STAGES;
  localparam int NSTAGE = OUT_IDX + 1;

  logic [NSTAGE-1:0] valid_q, valid_d;
  logic [NSTAGE:0]   en;

  q2e_pkg::sq_t  sq_pipe  [SQ+1];
  q2e_pkg::cor_t cor_pipe [CORDIC_STAGES+1];

  // a stage moves if it is empty or its successor moves
  assign en[NSTAGE] = angle_o.ready;
  genvar k;
  generate
    for (k = 0; k < NSTAGE; k++) begin : g_ctl
      assign en[k]      = !valid_q[k] || en[k+1];
      assign valid_d[k] = (k == 0) ? quat_i.valid : valid_q[(k == 0) ? 0 : k-1];
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_d[i];
        end
      end
    end
  end

  assign quat_i.ready  = en[0];
  assign angle_o.valid = valid_q[NSTAGE-1];

  q2e_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[FS-1:0]),
    .w_i    (quat_i.quat_w),
    .x_i    (quat_i.quat_x),
    .y_i    (quat_i.quat_y),
    .z_i    (quat_i.quat_z),
    .data_o (sq_pipe[0])
  );

  genvar j;
  generate
    for (j = 0; j < SQ; j++) begin : g_sqrt
      q2e_sqrt_step #(.STEP(j)) u_step (
        .clk_i  (clk_i),
        .en_i   (en[FS+j]),
        .data_i (sq_pipe[j]),
        .data_o (sq_pipe[j+1])
      );
    end
  endgenerate

  q2e_prerot u_prerot (
    .clk_i  (clk_i),
    .en_i   (en[PR_IDX]),
    .data_i (sq_pipe[SQ]),
    .data_o (cor_pipe[0])
  );

  genvar c;
  generate
    for (c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
      q2e_cordic_step #(.STEP(c)) u_step (
        .clk_i  (clk_i),
        .en_i   (en[CO_IDX+c]),
        .data_i (cor_pipe[c]),
        .data_o (cor_pipe[c+1])
      );
    end
  endgenerate

  q2e_out u_out (
    .clk_i   (clk_i),
    .en_i    (en[OUT_IDX]),
    .data_i  (cor_pipe[CORDIC_STAGES]),
    .roll_o  (angle_o.roll_angle),
    .pitch_o (angle_o.pitch_angle),
    .yaw_o   (angle_o.yaw_angle)
  );

endmodule

### src/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks on the angle channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "quat_to_euler_angles_unit_defines.svh"

module q2e_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] roll_i,
  input logic signed [14:0] pitch_i,
  input logic signed [15:0] yaw_i
);

  localparam logic signed [15:0] PI_LIM   = 16'sd25736;
  localparam logic signed [14:0] HALF_LIM = 15'sd12868;

  `Q2E_ASSERT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "stalled beat dropped")
  `Q2E_ASSERT(a_hold_data, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable({roll_i, pitch_i, yaw_i}), "stalled beat changed")
  `Q2E_ASSERT_RANGE(a_roll_rng, clk_i, rst_ni, out_valid_i, roll_i, PI_LIM, "roll out of range")
  `Q2E_ASSERT_RANGE(a_pitch_rng, clk_i, rst_ni, out_valid_i, pitch_i, HALF_LIM, "pitch out of range")
  `Q2E_ASSERT_RANGE(a_yaw_rng, clk_i, rst_ni, out_valid_i, yaw_i, PI_LIM, "yaw out of range")

endmodule

bind quat_to_euler_angles_unit q2e_checker u_q2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (angle_o.valid),
  .out_ready_i (angle_o.ready),
  .roll_i      (angle_o.roll_angle),
  .pitch_i     (angle_o.pitch_angle),
  .yaw_i       (angle_o.yaw_angle)
);

### bench/quat_to_euler_angles_unit_tb.sv
// ----------------------------------------------------------------------------
// quat_to_euler_angles_unit_tb
// Drives quaternion beats through the Euler angle unit and compares every
// angle beat with a bit-exact predictor; random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quat_to_euler_angles_unit_tb;

  localparam int N_STAGES = q2e_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY  = 34 + N_STAGES;
  localparam longint LIMIT_Q28 = 268432772;
  localparam longint HALF_PI   = 1686629713;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  q2e_quat_if  quat_i ();
  q2e_angle_if angle_o ();

  quat_to_euler_angles_unit #(.CORDIC_STAGES(N_STAGES)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_i.sink),
    .angle_o(angle_o.source)
  );

  angles_t expected_angles[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_cycles = 0;
  int      errors = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  longint  cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---- predictor ----
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                      524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                      2047, 1023, 511, 255, 127};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint num, longint den);
    longint cx, cy, acc, t, xs, ys;
    int n;
    cx = den; cy = num; acc = 0;
    n = (N_STAGES > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN : N_STAGES;
    if (cx == 0 && cy == 0) return 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; acc = HALF_PI;
      end else begin
        t = cx; cx = -cy; cy = t; acc = -HALF_PI;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = floor_shift(cx, i);
      ys = floor_shift(cy, i);
      if (cy >= 0) begin
        cx = cx + ys; cy = cy - xs; acc += atan_entry(i);
      end else begin
        cx = cx - ys; cy = cy + xs; acc -= atan_entry(i);
      end
    end
    return acc;
  endfunction

  function automatic longint to_q13(longint a, longint lim);
    longint r;
    r = floor_shift(a + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, s, sa, c;
    angles_t r;
    w = qw; x = qx; y = qy; z = qz;
    s = -2 * (x * z - w * y);
    if (s > LIMIT_Q28) s = LIMIT_Q28;
    if (s < -LIMIT_Q28) s = -LIMIT_Q28;
    sa = (s < 0) ? -s : s;
    c = int_sqrt((64'd1 << 56) - longint'(sa * sa));
    r.roll  = 16'(to_q13(vector_angle(2 * (y * z + w * x), w*w - x*x - y*y + z*z),
                         q2e_pkg::PI_Q13_MAX));
    r.pitch = 15'(to_q13(vector_angle(s, c), q2e_pkg::HALF_PI_Q13_MAX));
    r.yaw   = 16'(to_q13(vector_angle(2 * (x * y + w * z), w*w + x*x - y*y - z*z),
                         q2e_pkg::PI_Q13_MAX));
    return r;
  endfunction

  // ---- receiver ----
  initial begin
    angle_o.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        angle_o.ready <= 1'b0;
      end else begin
        angle_o.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    angles_t e;
    cycles <= cycles + 1;
    if (rst_ni && angle_o.valid && angle_o.ready) begin
      beats_out <= beats_out + 1;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected angle beat roll=%0d pitch=%0d yaw=%0d", $time,
                 angle_o.roll_angle, angle_o.pitch_angle, angle_o.yaw_angle);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (e.roll !== angle_o.roll_angle) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll,
                   angle_o.roll_angle);
          errors++;
        end
        if (e.pitch !== angle_o.pitch_angle) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                   angle_o.pitch_angle);
          errors++;
        end
        if (e.yaw !== angle_o.yaw_angle) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw,
                   angle_o.yaw_angle);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- sender ----
  task automatic send_quat(logic signed [15:0] qw, qx, qy, qz);
    while ($urandom_range(99) < send_idle_pct) begin
      quat_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    quat_i.valid  <= 1'b1;
    quat_i.quat_w <= qw;
    quat_i.quat_x <= qx;
    quat_i.quat_y <= qy;
    quat_i.quat_z <= qz;
    do @(posedge clk_i); while (!quat_i.ready);
    expected_angles.push_back(predict_angles(qw, qx, qy, qz));
    beats_in++;
  endtask

  task automatic stop_sending();
    quat_i.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_unit_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // roughly normalized quaternion with random content
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(2000)) - 1000);
    b = $itor($signed($urandom_range(2000)) - 1000);
    c = $itor($signed($urandom_range(2000)) - 1000);
    d = $itor($signed($urandom_range(2000)) - 1000);
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
              16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
  endtask

  task automatic test_directed();
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, -16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);                   // roll and yaw atan2 operands all zero
    send_quat(11585, 0, 11585, 0);           // pitch just below upper clamp
    send_quat(11585, 0, -11585, 0);          // pitch just above lower clamp
    send_quat(16384, 16384, 16384, 16384);   // non-unit quaternion
    send_quat(-16384, 16384, -16384, 16384);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    send_quat(0, 11585, 11585, 0);           // left half-plane roll denominator
    send_quat(1, -16384, 0, 1);
    stop_sending();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) send_unit_quat();
      else if ($urandom_range(1)) send_quat(rand_unit_comp(), rand_unit_comp(),
                                            rand_unit_comp(), rand_unit_comp());
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 3 * LATENCY;
    for (int i = 0; i < 150; i++) send_unit_quat();
    stop_sending();
  endtask

  initial begin
    quat_i.valid  <= 1'b0;
    quat_i.quat_w <= '0;
    quat_i.quat_x <= '0;
    quat_i.quat_y <= '0;
    quat_i.quat_z <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 57, 0);
    test_random(350, 0, 57);
    test_random(350, 35, 35);
    test_backpressure();
    recv_stall_pct = 20;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("run covered %0d quaternion beats, %0d angle beats checked", beats_in,
             beats_out);
    $display("phases: directed corners, four idling mixes, long output hold-off");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/q2e_pkg.sv
src/q2e_if.sv
src/q2e_front.sv
src/q2e_sqrt_step.sv
src/q2e_prerot.sv
src/q2e_cordic_step.sv
src/q2e_out.sv
src/quat_to_euler_angles_unit.sv
src/q2e_checker.sv
bench/quat_to_euler_angles_unit_tb.sv
